@@ src/sdsb_pkg.sv @@
package sdsb_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam int WAKE_BYTES  = 10;
   localparam int COUNT_MAX   = (BLOCK_BYTES > WAKE_BYTES) ? BLOCK_BYTES : WAKE_BYTES;
   localparam int COUNT_W     = $clog2(COUNT_MAX + 1);

   typedef logic [COUNT_W-1:0] count_type;

   // Host function codes.
   localparam logic [2:0] FUNC_INIT  = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_WRITE = 3'd2;
   localparam logic [2:0] FUNC_POLL  = 3'd3;
   localparam logic [2:0] FUNC_XFER  = 3'd4;

   // Card command indexes.
   localparam logic [5:0] CMD_RESET  = 6'd0;
   localparam logic [5:0] CMD_OPCOND = 6'd1;
   localparam logic [5:0] CMD_BLKLEN = 6'd16;
   localparam logic [5:0] CMD_READ   = 6'd17;
   localparam logic [5:0] CMD_WRITE  = 6'd24;

   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] CRC_RESET  = 8'h95;
   localparam logic [7:0] CMD_PREFIX = 8'h40;
   localparam logic [7:0] DATA_TOKEN = 8'hFE;
   localparam logic [7:0] STATUS_CMD = 8'h0D;

   localparam logic [3:0] INIT_FRAME_LEN = 4'd9;
   localparam logic [3:0] DATA_FRAME_LEN = 4'd7;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_WAKE,
      PH_FRAME,
      PH_R1,
      PH_TOKEN,
      PH_RDATA,
      PH_RCRC,
      PH_WFILL,
      PH_WTOKEN,
      PH_WDATA,
      PH_POLL,
      PH_PTAIL
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      count_type   byte_count;
      logic [31:0] addr;
      logic [7:0]  last_response;
      logic [5:0]  cmd_index;
   } state_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] mosi_byte;
      logic       select_low;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       read_last;
      logic       want_write_byte;
      logic       done_res;
      logic [7:0] response;
      logic       write_busy;
   } result_type;

   function automatic logic is_init_cmd(input logic [5:0] cmd);
      return (cmd == CMD_RESET) || (cmd == CMD_OPCOND) || (cmd == CMD_BLKLEN);
   endfunction

   // Byte k of a command frame; byte 0 and everything past the CRC are idle.
   function automatic logic [7:0] frame_byte(input logic [5:0] cmd,
                                             input logic [31:0] addr,
                                             input count_type k);
      logic [31:0] arg;
      logic [7:0]  b;
      arg = '0;
      if (cmd == CMD_BLKLEN) begin
         arg = 32'(BLOCK_BYTES);
      end else if ((cmd == CMD_READ) || (cmd == CMD_WRITE)) begin
         arg = addr;
      end
      unique case (k)
         count_type'(1): b = CMD_PREFIX | {2'b00, cmd};
         count_type'(2): b = arg[31:24];
         count_type'(3): b = arg[23:16];
         count_type'(4): b = arg[15:8];
         count_type'(5): b = arg[7:0];
         count_type'(6): b = (cmd == CMD_RESET) ? CRC_RESET : BYTE_IDLE;
         default:        b = BYTE_IDLE;
      endcase
      return b;
   endfunction

endpackage

@@ src/sdsb_step.sv @@
module sdsb_step
   import sdsb_pkg::*;
(
   input  state_type   state,
   input  logic [2:0]  func,
   input  logic [31:0] block_addr,
   input  logic [7:0]  miso_byte,
   input  logic [7:0]  write_byte,
   output logic        has_result,
   output state_type   next_state,
   output result_type  result
);

   count_type  cnt_inc;
   count_type  cnt_inc2;
   count_type  frame_len;
   logic       do_start;
   logic [5:0] start_cmd;
   logic       do_finish;
   logic       fin_busy;

   assign cnt_inc   = state.byte_count + count_type'(1);
   assign cnt_inc2  = state.byte_count + count_type'(2);
   assign frame_len = is_init_cmd(state.cmd_index) ? count_type'(INIT_FRAME_LEN)
                                                   : count_type'(DATA_FRAME_LEN);

   always_comb begin
      next_state = state;
      result     = '0;
      has_result = 1'b0;
      do_start   = 1'b0;
      start_cmd  = CMD_RESET;
      do_finish  = 1'b0;
      fin_busy   = 1'b0;

      if (func == FUNC_XFER) begin
         has_result = (state.phase != PH_IDLE);
         unique case (state.phase)
            PH_IDLE: begin
               has_result = 1'b0;
            end
            PH_WAKE: begin
               next_state.byte_count = cnt_inc;
               if (cnt_inc < count_type'(WAKE_BYTES)) begin
                  result.send_valid = 1'b1;
                  result.mosi_byte  = BYTE_IDLE;
               end else begin
                  do_start  = 1'b1;
                  start_cmd = CMD_RESET;
               end
            end
            PH_FRAME: begin
               next_state.byte_count = cnt_inc;
               if (cnt_inc < frame_len) begin
                  result.send_valid = 1'b1;
                  result.select_low = 1'b1;
                  result.mosi_byte  = frame_byte(state.cmd_index, state.addr, cnt_inc);
               end else if (!is_init_cmd(state.cmd_index)) begin
                  next_state.phase  = PH_R1;
                  result.send_valid = 1'b1;
                  result.select_low = 1'b1;
                  result.mosi_byte  = BYTE_IDLE;
               end else begin
                  next_state.last_response = miso_byte;
                  if (state.cmd_index == CMD_RESET) begin
                     do_start  = 1'b1;
                     start_cmd = CMD_OPCOND;
                  end else if (state.cmd_index == CMD_OPCOND) begin
                     do_start  = 1'b1;
                     start_cmd = (miso_byte != 8'h00) ? CMD_OPCOND : CMD_BLKLEN;
                  end else if (miso_byte == BYTE_IDLE) begin
                     do_start  = 1'b1;
                     start_cmd = CMD_BLKLEN;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
            end
            PH_R1: begin
               if (miso_byte != BYTE_IDLE) begin
                  next_state.last_response = miso_byte;
                  next_state.byte_count    = '0;
                  next_state.phase = (state.cmd_index == CMD_READ) ? PH_TOKEN : PH_WFILL;
               end
               result.send_valid = 1'b1;
               result.select_low = 1'b1;
               result.mosi_byte  = BYTE_IDLE;
            end
            PH_TOKEN: begin
               if (miso_byte != BYTE_IDLE) begin
                  next_state.phase      = PH_RDATA;
                  next_state.byte_count = '0;
               end
               result.send_valid = 1'b1;
               result.select_low = 1'b1;
               result.mosi_byte  = BYTE_IDLE;
            end
            PH_RDATA: begin
               result.send_valid = 1'b1;
               result.select_low = 1'b1;
               result.mosi_byte  = BYTE_IDLE;
               result.read_byte  = miso_byte;
               result.read_valid = 1'b1;
               if (cnt_inc >= count_type'(BLOCK_BYTES)) begin
                  result.read_last      = 1'b1;
                  next_state.phase      = PH_RCRC;
                  next_state.byte_count = '0;
               end else begin
                  next_state.byte_count = cnt_inc;
               end
            end
            PH_RCRC: begin
               next_state.byte_count = cnt_inc;
               if (cnt_inc < count_type'(2)) begin
                  result.send_valid = 1'b1;
                  result.select_low = 1'b1;
                  result.mosi_byte  = BYTE_IDLE;
               end else begin
                  do_finish = 1'b1;
               end
            end
            PH_WFILL: begin
               next_state.byte_count = cnt_inc;
               result.send_valid     = 1'b1;
               result.select_low     = 1'b1;
               if (cnt_inc < count_type'(3)) begin
                  result.mosi_byte = BYTE_IDLE;
               end else begin
                  next_state.phase       = PH_WTOKEN;
                  result.mosi_byte       = DATA_TOKEN;
                  result.want_write_byte = 1'b1;
               end
            end
            PH_WTOKEN: begin
               next_state.phase       = PH_WDATA;
               next_state.byte_count  = '0;
               result.send_valid      = 1'b1;
               result.select_low      = 1'b1;
               result.mosi_byte       = write_byte;
               result.want_write_byte = (BLOCK_BYTES > 1);
            end
            PH_WDATA: begin
               next_state.byte_count = cnt_inc;
               if (cnt_inc < count_type'(BLOCK_BYTES)) begin
                  result.send_valid      = 1'b1;
                  result.select_low      = 1'b1;
                  result.mosi_byte       = write_byte;
                  result.want_write_byte = (cnt_inc2 < count_type'(BLOCK_BYTES));
               end else begin
                  do_finish = 1'b1;
               end
            end
            PH_POLL: begin
               next_state.last_response = miso_byte;
               if (miso_byte == BYTE_IDLE) begin
                  do_finish = 1'b1;
                  fin_busy  = 1'b1;
               end else begin
                  next_state.phase      = PH_PTAIL;
                  next_state.byte_count = '0;
                  result.send_valid     = 1'b1;
                  result.mosi_byte      = BYTE_IDLE;
               end
            end
            PH_PTAIL: begin
               next_state.byte_count = cnt_inc;
               if (cnt_inc < count_type'(3)) begin
                  result.send_valid = 1'b1;
                  result.mosi_byte  = BYTE_IDLE;
               end else begin
                  do_finish = 1'b1;
               end
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end else if ((state.phase == PH_IDLE) && (func < FUNC_XFER)) begin
         has_result = 1'b1;
         unique case (func)
            FUNC_INIT: begin
               next_state.phase      = PH_WAKE;
               next_state.byte_count = '0;
               result.send_valid     = 1'b1;
               result.mosi_byte      = BYTE_IDLE;
            end
            FUNC_READ: begin
               next_state.addr = block_addr;
               do_start        = 1'b1;
               start_cmd       = CMD_READ;
            end
            FUNC_WRITE: begin
               next_state.addr = block_addr;
               do_start        = 1'b1;
               start_cmd       = CMD_WRITE;
            end
            default: begin
               next_state.phase      = PH_POLL;
               next_state.byte_count = '0;
               result.send_valid     = 1'b1;
               result.select_low     = 1'b1;
               result.mosi_byte      = STATUS_CMD;
            end
         endcase
      end

      if (do_start) begin
         next_state.cmd_index  = start_cmd;
         next_state.phase      = PH_FRAME;
         next_state.byte_count = '0;
         result                = '0;
         result.send_valid     = 1'b1;
         result.select_low     = 1'b1;
         result.mosi_byte      = frame_byte(start_cmd, next_state.addr, '0);
      end
      if (do_finish) begin
         next_state.phase      = PH_IDLE;
         next_state.byte_count = '0;
         result                = '0;
         result.done_res       = 1'b1;
         result.write_busy     = fin_busy;
      end
      result.response = next_state.last_response;
   end

endmodule

@@ src/sdsb_out_buf.sv @@
module sdsb_out_buf
   import sdsb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // A push never arrives while the skid entry is full.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff) begin
         if (pop && push) begin
            main_in = push_data;
         end else if (pop) begin
            main_valid_in = 1'b0;
         end else if (push) begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (push) begin
         main_in       = push_data;
         main_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

@@ src/sd_spi_block_sequencer.sv @@
// Results are registered in the result buffer and presented on the rsp_ channel from there.
// Throughput: one request transaction per cycle while the result buffer has space, set by the
// combinational step logic that decides each finished SPI exchange, with a two-entry result buffer
// that keeps accepting while one result waits. Reset (synchronous, active high) returns the sequencer
// to idle, clears the byte count, command index and address, sets the captured response to 0xFF,
// and empties the result buffer.
module sd_spi_block_sequencer
   import sdsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_block_addr,
   input  logic [7:0]  req_miso_byte,
   input  logic [7:0]  req_write_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_valid,
   output logic [7:0]  rsp_mosi_byte,
   output logic        rsp_select_low,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_valid,
   output logic        rsp_read_last,
   output logic        rsp_want_write_byte,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_response,
   output logic        rsp_write_busy
);

   state_type  state_ff;
   state_type  state_in;
   state_type  step_state;
   result_type step_result;
   result_type out_data;
   logic       step_has_result;
   logic       req_fire;
   logic       buf_space;

   assign req_ready = buf_space;
   assign req_fire  = req_valid && req_ready;

   // The step logic sees the current sequencer state and the offered transaction. Ignored
   // transactions (requests while busy, exchanges while idle, unknown functions) leave the
   // state unchanged and produce no result.
   sdsb_step u_step (
      .state      (state_ff),
      .func       (req_func),
      .block_addr (req_block_addr),
      .miso_byte  (req_miso_byte),
      .write_byte (req_write_byte),
      .has_result (step_has_result),
      .next_state (step_state),
      .result     (step_result)
   );

   assign state_in = req_fire ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_IDLE;
         state_ff.byte_count    <= '0;
         state_ff.addr          <= '0;
         state_ff.last_response <= BYTE_IDLE;
         state_ff.cmd_index     <= CMD_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // Results are buffered so the next exchange can be decided while one still waits.
   sdsb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire && step_has_result),
      .push_data (step_result),
      .space     (buf_space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_send_valid      = out_data.send_valid;
   assign rsp_mosi_byte       = out_data.mosi_byte;
   assign rsp_select_low      = out_data.select_low;
   assign rsp_read_byte       = out_data.read_byte;
   assign rsp_read_valid      = out_data.read_valid;
   assign rsp_read_last       = out_data.read_last;
   assign rsp_want_write_byte = out_data.want_write_byte;
   assign rsp_done_res        = out_data.done_res;
   assign rsp_response        = out_data.response;
   assign rsp_write_busy      = out_data.write_busy;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sdsb_pkg::*;

   // The random phase stops the sender once this many of its transactions
   // have produced results. Block transfers are covered by their own tests.
   localparam int unsigned RANDOM_ITEMS     = 100;
   localparam int unsigned LONG_HOLD_CYCLES = 60;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned MAX_REPORTS      = 10;
   localparam longint     TIMEOUT_NS        = 2_000_000;

   // Function codes above FUNC_XFER are not defined; the sequencer drops them.
   localparam logic [2:0] FUNC_FIRST_UNUSED = FUNC_XFER + 3'd1;
   localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_EVERY_THIRD,
      RX_HEAVY
   } rx_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = FUNC_INIT;
   logic [31:0] req_block_addr = '0;
   logic [7:0]  req_miso_byte = '0;
   logic [7:0]  req_write_byte = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_send_valid;
   logic [7:0]  rsp_mosi_byte;
   logic        rsp_select_low;
   logic [7:0]  rsp_read_byte;
   logic        rsp_read_valid;
   logic        rsp_read_last;
   logic        rsp_want_write_byte;
   logic        rsp_done_res;
   logic [7:0]  rsp_response;
   logic        rsp_write_busy;

   sd_spi_block_sequencer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_block_addr      (req_block_addr),
      .req_miso_byte       (req_miso_byte),
      .req_write_byte      (req_write_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_mosi_byte       (rsp_mosi_byte),
      .rsp_select_low      (rsp_select_low),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_read_last       (rsp_read_last),
      .rsp_want_write_byte (rsp_want_write_byte),
      .rsp_done_res        (rsp_done_res),
      .rsp_response        (rsp_response),
      .rsp_write_busy      (rsp_write_busy)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predicted sequencer state. This mirrors what the block should hold after
   // every accepted transaction, and it also tells the card model below which
   // exchange the host is in, so the stimulus can answer like a real card.
   // ------------------------------------------------------------------------
   phase_type   seq_phase = PH_IDLE;
   int unsigned seq_count = 0;
   logic [31:0] seq_addr  = '0;
   logic [7:0]  seq_resp  = BYTE_IDLE;
   logic [5:0]  seq_cmd   = CMD_RESET;

   // Results that the sequencer owes us, oldest first.
   result_type  owed_spi_steps[$];

   // Card behavior for the operation in flight. The wait counters say how many
   // more times the card answers "not ready" before it gives its real answer.
   logic [7:0]  cmd0_reply        = 8'h01;
   int unsigned opcond_busy_left  = 0;
   int unsigned blklen_busy_left  = 0;
   logic [7:0]  blklen_reply      = 8'h00;
   int unsigned r1_wait_left      = 0;
   logic [7:0]  r1_reply          = 8'h00;
   int unsigned token_wait_left   = 0;
   logic [7:0]  token_reply       = DATA_TOKEN;
   logic [7:0]  poll_reply        = 8'h00;

   // Sender burst control and the receiver's long holdoff request.
   bit          sender_gaps       = 1'b1;
   int unsigned burst_left        = 0;
   bit          long_hold_pending = 1'b0;

   // Bookkeeping.
   int unsigned mismatches      = 0;
   int unsigned results_checked = 0;
   int unsigned results_owed    = 0;
   int unsigned ignored_items   = 0;
   int unsigned long_holds      = 0;
   int unsigned init_ops        = 0;
   int unsigned read_ops        = 0;
   int unsigned write_ops       = 0;
   int unsigned poll_ops        = 0;

   // ------------------------------------------------------------------------
   // Predictor helpers.
   // ------------------------------------------------------------------------
   function automatic bit command_is_init();
      return (seq_cmd == CMD_RESET) || (seq_cmd == CMD_OPCOND) || (seq_cmd == CMD_BLKLEN);
   endfunction

   function automatic int unsigned frame_bytes();
      return command_is_init() ? int'(INIT_FRAME_LEN) : int'(DATA_FRAME_LEN);
   endfunction

   // The full nine-byte frame laid out as one vector: a leading idle byte, the
   // command byte, four argument bytes, the CRC and two trailing idle bytes.
   function automatic logic [7:0] frame_byte_at(input int unsigned k);
      logic [31:0] arg;
      logic [7:0]  crc;
      logic [71:0] frame;
      arg = '0;
      if (seq_cmd == CMD_BLKLEN) begin
         arg = 32'(BLOCK_BYTES);
      end else if ((seq_cmd == CMD_READ) || (seq_cmd == CMD_WRITE)) begin
         arg = seq_addr;
      end
      crc   = (seq_cmd == CMD_RESET) ? CRC_RESET : BYTE_IDLE;
      frame = {BYTE_IDLE, CMD_PREFIX | {2'b00, seq_cmd}, arg, crc, BYTE_IDLE, BYTE_IDLE};
      return frame[71 - 8 * k -: 8];
   endfunction

   // A plain "exchange this byte next" result.
   function automatic result_type spi_out(input logic [7:0] mosi, input logic sel);
      result_type r;
      r            = '0;
      r.send_valid = 1'b1;
      r.mosi_byte  = mosi;
      r.select_low = sel;
      r.response   = seq_resp;
      return r;
   endfunction

   function automatic result_type op_done(input logic busy);
      result_type r;
      seq_phase    = PH_IDLE;
      seq_count    = 0;
      r            = '0;
      r.done_res   = 1'b1;
      r.write_busy = busy;
      r.response   = seq_resp;
      return r;
   endfunction

   function automatic result_type open_frame(input logic [5:0] cmd);
      seq_cmd   = cmd;
      seq_phase = PH_FRAME;
      seq_count = 0;
      return spi_out(frame_byte_at(0), 1'b1);
   endfunction

   // End of a command frame. Data commands go on to wait for R1; the init
   // commands capture the last byte and pick the next command from it.
   function automatic result_type close_frame(input logic [7:0] miso);
      if (!command_is_init()) begin
         seq_phase = PH_R1;
         return spi_out(BYTE_IDLE, 1'b1);
      end
      seq_resp = miso;
      if (seq_cmd == CMD_RESET) begin
         return open_frame(CMD_OPCOND);
      end else if (seq_cmd == CMD_OPCOND) begin
         return open_frame((miso != 8'h00) ? CMD_OPCOND : CMD_BLKLEN);
      end else if (miso == BYTE_IDLE) begin
         return open_frame(CMD_BLKLEN);
      end
      return op_done(1'b0);
   endfunction

   function automatic result_type advance_exchange(input logic [7:0] miso,
                                                   input logic [7:0] wb);
      result_type r;
      bit         last;
      r = '0;
      case (seq_phase)
         PH_WAKE: begin
            seq_count++;
            if (seq_count < WAKE_BYTES) r = spi_out(BYTE_IDLE, 1'b0);
            else r = open_frame(CMD_RESET);
         end
         PH_FRAME: begin
            seq_count++;
            if (seq_count < frame_bytes()) r = spi_out(frame_byte_at(seq_count), 1'b1);
            else r = close_frame(miso);
         end
         PH_R1: begin
            if (miso != BYTE_IDLE) begin
               seq_resp  = miso;
               seq_count = 0;
               seq_phase = (seq_cmd == CMD_READ) ? PH_TOKEN : PH_WFILL;
            end
            r = spi_out(BYTE_IDLE, 1'b1);
         end
         PH_TOKEN: begin
            // Any byte other than idle counts as the start of data.
            if (miso != BYTE_IDLE) begin
               seq_phase = PH_RDATA;
               seq_count = 0;
            end
            r = spi_out(BYTE_IDLE, 1'b1);
         end
         PH_RDATA: begin
            last = (seq_count + 1 >= BLOCK_BYTES);
            if (last) begin
               seq_phase = PH_RCRC;
               seq_count = 0;
            end else begin
               seq_count++;
            end
            r            = spi_out(BYTE_IDLE, 1'b1);
            r.read_byte  = miso;
            r.read_valid = 1'b1;
            r.read_last  = last;
         end
         PH_RCRC: begin
            seq_count++;
            if (seq_count < 2) r = spi_out(BYTE_IDLE, 1'b1);
            else r = op_done(1'b0);
         end
         PH_WFILL: begin
            seq_count++;
            if (seq_count < 3) begin
               r = spi_out(BYTE_IDLE, 1'b1);
            end else begin
               seq_phase         = PH_WTOKEN;
               r                 = spi_out(DATA_TOKEN, 1'b1);
               r.want_write_byte = 1'b1;
            end
         end
         PH_WTOKEN: begin
            seq_phase         = PH_WDATA;
            seq_count         = 0;
            r                 = spi_out(wb, 1'b1);
            r.want_write_byte = (BLOCK_BYTES > 1);
         end
         PH_WDATA: begin
            seq_count++;
            if (seq_count < BLOCK_BYTES) begin
               r                 = spi_out(wb, 1'b1);
               r.want_write_byte = (seq_count + 1 < BLOCK_BYTES);
            end else begin
               r = op_done(1'b0);
            end
         end
         PH_POLL: begin
            seq_resp = miso;
            if (miso == BYTE_IDLE) begin
               r = op_done(1'b1);
            end else begin
               seq_phase = PH_PTAIL;
               seq_count = 0;
               r         = spi_out(BYTE_IDLE, 1'b0);
            end
         end
         default: begin
            seq_count++;
            if (seq_count < 3) r = spi_out(BYTE_IDLE, 1'b0);
            else r = op_done(1'b0);
         end
      endcase
      return r;
   endfunction

   // Applies one accepted transaction to the predicted state. Returns 1 and the
   // expected result when the sequencer must answer, 0 when it drops the item.
   function automatic bit step_sequencer(input logic [2:0] func, input logic [31:0] addr,
                                         input logic [7:0] miso, input logic [7:0] wb,
                                         output result_type r);
      r = '0;
      if (func == FUNC_XFER) begin
         if (seq_phase == PH_IDLE) return 1'b0;
         r = advance_exchange(miso, wb);
         return 1'b1;
      end
      if ((func > FUNC_XFER) || (seq_phase != PH_IDLE)) return 1'b0;
      case (func)
         FUNC_INIT: begin
            seq_phase = PH_WAKE;
            seq_count = 0;
            r         = spi_out(BYTE_IDLE, 1'b0);
         end
         FUNC_READ: begin
            seq_addr = addr;
            r        = open_frame(CMD_READ);
         end
         FUNC_WRITE: begin
            seq_addr = addr;
            r        = open_frame(CMD_WRITE);
         end
         default: begin
            seq_phase = PH_POLL;
            seq_count = 0;
            r         = spi_out(STATUS_CMD, 1'b1);
         end
      endcase
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Card model: the byte the card returns during the exchange that the host
   // is about to report. Only the bytes the sequencer actually looks at follow
   // the card policy; everything else is random traffic on the line.
   // ------------------------------------------------------------------------
   function automatic logic [7:0] card_reply();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      case (seq_phase)
         PH_FRAME: begin
            if (command_is_init() && (seq_count + 1 == frame_bytes())) begin
               if (seq_cmd == CMD_RESET) begin
                  b = cmd0_reply;
               end else if (seq_cmd == CMD_OPCOND) begin
                  if (opcond_busy_left > 0) begin
                     opcond_busy_left--;
                     b = 8'($urandom_range(1, 255));
                  end else begin
                     b = 8'h00;
                  end
               end else if (blklen_busy_left > 0) begin
                  blklen_busy_left--;
                  b = BYTE_IDLE;
               end else begin
                  b = blklen_reply;
               end
            end
         end
         PH_R1: begin
            if (r1_wait_left > 0) begin
               r1_wait_left--;
               b = BYTE_IDLE;
            end else begin
               b = r1_reply;
            end
         end
         PH_TOKEN: begin
            if (token_wait_left > 0) begin
               token_wait_left--;
               b = BYTE_IDLE;
            end else begin
               b = token_reply;
            end
         end
         PH_POLL: b = poll_reply;
         default: ;
      endcase
      return b;
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Drives one transaction and holds it until accepted, then updates
   // the prediction. Valid is left high so that a following call in the same
   // time step continues the burst; anything that waits lowers it first.
   // ------------------------------------------------------------------------
   task automatic offer(input logic [2:0] func, input logic [31:0] addr,
                        input logic [7:0] miso, input logic [7:0] wb);
      result_type r;
      bit         answers;
      req_valid      <= 1'b1;
      req_func       <= func;
      req_block_addr <= addr;
      req_miso_byte  <= miso;
      req_write_byte <= wb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      answers = step_sequencer(func, addr, miso, wb, r);
      if (answers) begin
         owed_spi_steps.push_back(r);
         results_owed++;
      end else begin
         ignored_items++;
      end
      // Bursts of random length separated by random gaps.
      if (sender_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   // A transaction the sequencer must drop: a request while it is busy, an
   // undefined function code, or an exchange report while it is idle.
   task automatic offer_noise();
      logic [2:0] func;
      case ($urandom_range(0, 2))
         0: func = 3'($urandom_range(FUNC_INIT, FUNC_POLL));
         1: func = 3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
         default: func = (seq_phase == PH_IDLE) ? FUNC_XFER
                                                : 3'($urandom_range(FUNC_INIT, FUNC_POLL));
      endcase
      // Only idle-time requests of 0..3 would be accepted, so avoid them here.
      if ((seq_phase == PH_IDLE) && (func <= FUNC_POLL)) func = FUNC_XFER;
      offer(func, $urandom, 8'($urandom), 8'($urandom));
   endtask

   // Starts one host operation and plays the card until the sequencer reports
   // it finished. noise_per_mille sprinkles dropped transactions in between.
   task automatic run_operation(input logic [2:0] func, input logic [31:0] addr,
                                input int unsigned noise_per_mille);
      case (func)
         FUNC_INIT:  init_ops++;
         FUNC_READ:  read_ops++;
         FUNC_WRITE: write_ops++;
         default:    poll_ops++;
      endcase
      offer(func, addr, 8'($urandom), 8'($urandom));
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(0, 999) < noise_per_mille) offer_noise();
         offer(FUNC_XFER, $urandom, card_reply(), 8'($urandom));
      end
   endtask

   // Stop offering and wait until every owed result has been checked.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_spi_steps.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test cases.
   // ------------------------------------------------------------------------

   // Exchange reports and undefined codes at idle must produce nothing.
   task automatic test_ignored_while_idle();
      offer(FUNC_XFER, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      offer(FUNC_FIRST_UNUSED, 32'h0000_0000, 8'h00, 8'h00);
      offer(FUNC_FIRST_UNUSED + 3'd1, 32'hA5A5_5A5A, 8'h5A, 8'hA5);
      offer(FUNC_LAST_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'h00);
      settle();
   endtask

   // Power-up: the card stays busy on CMD1 twice and answers CMD16 with idle
   // once, so both retry loops are exercised. A few requests arrive mid-way.
   task automatic test_power_up();
      cmd0_reply       = 8'h01;
      opcond_busy_left = 2;
      blklen_busy_left = 1;
      blklen_reply     = 8'h00;
      run_operation(FUNC_INIT, 32'hFFFF_FFFF, 80);
      settle();
   endtask

   // Status poll: a busy card (idle answer) finishes at once with write_busy,
   // any other answer adds the three trailing exchanges with select high.
   task automatic test_status_poll();
      poll_reply = BYTE_IDLE;
      run_operation(FUNC_POLL, 32'h0000_0000, 0);
      poll_reply = 8'h00;
      run_operation(FUNC_POLL, 32'hFFFF_FFFF, 0);
      poll_reply = 8'hFE;
      run_operation(FUNC_POLL, 32'h1234_5678, 0);
      settle();
   endtask

   // Full block read at the top address with waits before R1 and the token,
   // and requests thrown at the busy sequencer.
   task automatic test_block_read();
      r1_wait_left    = 2;
      r1_reply        = 8'h00;
      token_wait_left = 3;
      token_reply     = DATA_TOKEN;
      run_operation(FUNC_READ, 32'hFFFF_FFFF, 40);
      settle();
   endtask

   // Full block write at address zero; the card's R1 is an error code, which
   // the sequencer still treats as a response and proceeds with.
   task automatic test_block_write();
      r1_wait_left = 0;
      r1_reply     = 8'h05;
      run_operation(FUNC_WRITE, 32'h0000_0000, 0);
      settle();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // back-to-back transactions, so the result buffer fills and the request
   // side has to stall.
   task automatic test_backpressure();
      sender_gaps       = 1'b0;
      long_hold_pending = 1'b1;
      for (int i = 0; i < 8; i++) begin
         poll_reply = (i % 2 == 0) ? 8'h00 : BYTE_IDLE;
         run_operation(FUNC_POLL, $urandom, 0);
      end
      sender_gaps = 1'b1;
      settle();
   endtask

   // Random inits and polls with random card behavior. Block transfers are
   // left to their own tests since each takes a whole block of exchanges.
   task automatic test_random_traffic();
      int unsigned start_owed;
      int unsigned pick;
      start_owed = results_owed;
      while (results_owed - start_owed < RANDOM_ITEMS) begin
         cmd0_reply       = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01;
         opcond_busy_left = $urandom_range(0, 3);
         blklen_busy_left = $urandom_range(0, 2);
         blklen_reply     = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254)) : 8'h00;
         case ($urandom_range(0, 2))
            0:       poll_reply = BYTE_IDLE;
            1:       poll_reply = 8'h00;
            default: poll_reply = 8'($urandom_range(0, 254));
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 3)) offer_noise();
         end else if (pick < 45) begin
            run_operation(FUNC_INIT, $urandom, 30);
         end else begin
            run_operation(FUNC_POLL, $urandom, 30);
         end
      end
      settle();
   endtask

   // ------------------------------------------------------------------------
   // Receiver. Switches between random stall patterns, including stretches
   // where it never stalls, and performs the long holdoff when asked.
   // ------------------------------------------------------------------------
   initial begin
      rx_pattern_type rx_mode;
      int unsigned    rx_cycle;
      rx_mode  = RX_OPEN;
      rx_cycle = 0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_holds++;
         end
         rx_cycle++;
         if (rx_cycle % 50 == 0) rx_mode = rx_pattern_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_OPEN:        rsp_ready <= 1'b1;
            RX_LIGHT:       rsp_ready <= ($urandom_range(0, 9) < 7);
            RX_EVERY_THIRD: rsp_ready <= (rx_cycle % 3 == 0);
            default:        rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Result checker. Every accepted result transaction is compared field by
   // field with the oldest owed result.
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: result %0d, %s: expected 0x%02h, got 0x%02h",
                  $realtime, results_checked, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.send_valid      = rsp_send_valid;
         got.mosi_byte       = rsp_mosi_byte;
         got.select_low      = rsp_select_low;
         got.read_byte       = rsp_read_byte;
         got.read_valid      = rsp_read_valid;
         got.read_last       = rsp_read_last;
         got.want_write_byte = rsp_want_write_byte;
         got.done_res        = rsp_done_res;
         got.response        = rsp_response;
         got.write_busy      = rsp_write_busy;
         if (owed_spi_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: result transaction arrived with none outstanding", $realtime);
            end
         end else begin
            want = owed_spi_steps.pop_front();
            if (got.send_valid !== want.send_valid)
               note_mismatch("send_valid", 8'(want.send_valid), 8'(got.send_valid));
            if (got.mosi_byte !== want.mosi_byte)
               note_mismatch("mosi_byte", want.mosi_byte, got.mosi_byte);
            if (got.select_low !== want.select_low)
               note_mismatch("select_low", 8'(want.select_low), 8'(got.select_low));
            if (got.read_byte !== want.read_byte)
               note_mismatch("read_byte", want.read_byte, got.read_byte);
            if (got.read_valid !== want.read_valid)
               note_mismatch("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            if (got.read_last !== want.read_last)
               note_mismatch("read_last", 8'(want.read_last), 8'(got.read_last));
            if (got.want_write_byte !== want.want_write_byte)
               note_mismatch("want_write_byte", 8'(want.want_write_byte),
                             8'(got.want_write_byte));
            if (got.done_res !== want.done_res)
               note_mismatch("done_res", 8'(want.done_res), 8'(got.done_res));
            if (got.response !== want.response)
               note_mismatch("response", want.response, got.response);
            if (got.write_busy !== want.write_busy)
               note_mismatch("write_busy", 8'(want.write_busy), 8'(got.write_busy));
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_ignored_while_idle();
      test_power_up();
      test_status_poll();
      test_block_read();
      test_block_write();
      test_backpressure();
      test_random_traffic();

      // Give a stray extra result a chance to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d inits, %0d block reads, %0d block writes and %0d status polls;",
               init_ops, read_ops, write_ops, poll_ops);
      $display("%0d results checked, %0d transactions dropped as expected, %0d long holdoff(s).",
               results_checked, ignored_items, long_holds);
      if ((mismatches == 0) && (owed_spi_steps.size() == 0)) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Safety net for a hung handshake or an endless card wait.
   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d results still outstanding.", owed_spi_steps.size());
      $display("tb_top: errors");
      $finish;
   end

endmodule
